FILE: src/sstbl_pkg.sv
// Package with the types and constants of the sorted sector range table.
package sstbl_pkg;

   localparam int MaxEntries = 8192;
   localparam int BlockBytes = 2048;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = $clog2(MaxEntries + 1);
   localparam int ShiftBits = $clog2(BlockBytes);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [23:0] sector;
      logic [31:0] byte_size;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [23:0] range_start;
      logic [23:0] range_end;
      logic        rejected;
   } rsp_type;

endpackage

FILE: src/sorted_sector_range_table_unit.sv
// Top level of the sorted sector range table: sequencer, entry memory and result register.
//
// The block keeps up to MaxEntries sector ranges ordered by start sector.
// Items arrive on the req_ channel (valid/stall); each item gives exactly
// one result on the rsp_ channel. A lookup binary-searches the table one
// probe at a time; each probe is a bound check, a memory read and a
// compare. An insert runs the same search for its place, then moves every
// later entry up by one, one entry at a time (read, then write). The block
// takes one item at a time and holds req_stall high while it works.
// The result waits in an output register; while the receiver stalls, the
// block keeps it there and accepts no new item until it is taken.
// Reset empties the table at once by clearing the entry count; the memory
// contents are not cleared, since entries at or above the count are never
// read.
module sorted_sector_range_table_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sstbl_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sstbl_pkg::rsp_type  rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_READ  = 8'b0000_0010,
      ST_CMP   = 8'b0000_0100,
      ST_MREAD = 8'b0000_1000,
      ST_MWRT  = 8'b0001_0000,
      ST_PUT   = 8'b0010_0000,
      ST_DONE  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   localparam int CntW = sstbl_pkg::CntW;
   localparam int IdxW = sstbl_pkg::IdxW;

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW:0] lo_ff, lo_in, hi_ff, hi_in;   // signed-style search bounds
   logic [CntW-1:0] mid_ff, mid_in;
   logic [CntW-1:0] mv_ff, mv_in;               // slot that the entry being moved up fills
   sstbl_pkg::req_type req_ff, req_in;
   logic [23:0] end_ff, end_in;
   logic rsp_valid_ff, rsp_valid_in;
   sstbl_pkg::rsp_type rsp_ff, rsp_in;

   logic [47:0] mem [sstbl_pkg::MaxEntries];
   logic [47:0] rd_ff;
   logic        we;
   logic [IdxW-1:0] waddr, raddr;
   logic [47:0] wdata;

   logic [CntW:0] sum;
   logic [24:0] end_sum;
   logic is_lookup;
   logic [23:0] rs, re;

   assign rs = rd_ff[47:24];
   assign re = rd_ff[23:0];
   assign is_lookup = (req_ff.operation == sstbl_pkg::OP_LOOKUP);
   assign sum = lo_ff + hi_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      mv_in = mv_ff;
      req_in = req_ff;
      end_in = end_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      we = 1'b0;
      waddr = mv_ff[IdxW-1:0];
      wdata = rd_ff;
      raddr = mid_ff[IdxW-1:0];
      end_sum = 25'(req_ff.sector)
              + 25'((req_ff.byte_size - 32'd1) >> sstbl_pkg::ShiftBits);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               lo_in = '0;
               state_in = ST_DONE;
               case (sstbl_pkg::op_type'(req_data.operation))
                  sstbl_pkg::OP_LOOKUP: begin
                     hi_in = {1'b0, count_ff} - 1'b1;
                     state_in = ST_CMP;
                     mid_in = '0;
                  end
                  sstbl_pkg::OP_INSERT: begin
                     hi_in = {1'b0, count_ff};
                     if (count_ff >= CntW'(sstbl_pkg::MaxEntries)) begin
                        rsp_in.rejected = 1'b1;
                     end else begin
                        state_in = ST_CMP;
                     end
                  end
                  sstbl_pkg::OP_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         ST_CMP: begin
            // Check loop condition and issue the probe of the midpoint.
            if (is_lookup ? ($signed(lo_ff) <= $signed(hi_ff)) : (lo_ff < hi_ff)) begin
               mid_in = sum[CntW:1];
               state_in = ST_READ;
            end else if (is_lookup) begin
               state_in = ST_DONE;
            end else begin
               if (req_ff.byte_size == 32'd0) end_in = req_ff.sector;
               else if (end_sum[24]) end_in = 24'hFFFFFF;
               else end_in = end_sum[23:0];
               mv_in = count_ff;
               state_in = ST_MREAD;
            end
         end
         ST_READ: begin
            // Read address is mid_ff this cycle; data arrives next cycle.
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (is_lookup) begin
               if (rs <= req_ff.sector && re >= req_ff.sector) begin
                  rsp_in.hit = 1'b1;
                  rsp_in.range_start = rs;
                  rsp_in.range_end = re;
                  state_in = ST_DONE;
               end else begin
                  if (rs > req_ff.sector) hi_in = {1'b0, mid_ff} - 1'b1;
                  else lo_in = {1'b0, mid_ff} + 1'b1;
                  state_in = ST_CMP;
               end
            end else begin
               if (rs > req_ff.sector) hi_in = {1'b0, mid_ff};
               else lo_in = {1'b0, mid_ff} + 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_MREAD: begin
            // Move entries above the insert place up by one, top first.
            if ({1'b0, mv_ff} > lo_ff) begin
               raddr = IdxW'(mv_ff - 1'b1);
               state_in = ST_MWRT;
            end else begin
               we = 1'b1;
               waddr = lo_ff[IdxW-1:0];
               wdata = {req_ff.sector, end_ff};
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_MWRT: begin
            we = 1'b1;
            mv_in = mv_ff - 1'b1;
            state_in = ST_MREAD;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      mv_ff <= mv_in;
      req_ff <= req_in;
      end_ff <= end_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the sorted sector range table unit.
`timescale 1ns / 1ps

// The testbench has two parts:
// 1. A short directed table covers the field extremes, every operation,
//    end saturation, equal starts and the unused operation code.
// 2. A random pass keeps the table small with frequent clears. Its lookups
//    mostly aim at stored ranges.
// A predictor that mirrors the table's binary searches computes every
// expected result. Directed rows with obvious answers carry the expected
// result typed in.
module testbench;

   localparam int NumRandom = 1832;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   sstbl_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   sstbl_pkg::rsp_type rsp_data;

   sorted_sector_range_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The predictor's own copy of the table.
   logic [23:0] table_starts [sstbl_pkg::MaxEntries];
   logic [23:0] table_ends [sstbl_pkg::MaxEntries];
   int          table_count;

   sstbl_pkg::rsp_type pending_results [$];
   int      error_count;
   int      n_hits, n_misses, n_inserts, n_refused, n_clears;
   bit      quiet_mode;
   bit      stimulus_done;

   // Directed stimulus. When known is set, the row's result is typed in.
   typedef struct {
      sstbl_pkg::op_type  op;
      logic [23:0]        sector;
      logic [31:0]        size;
      bit                 known;
      sstbl_pkg::rsp_type result;
   } directed_row;

   localparam sstbl_pkg::rsp_type NoResult = '{default: '0};

   directed_row directed_rows [] = '{
      '{sstbl_pkg::OP_LOOKUP, 24'd0, 32'd0, 1, NoResult},
      '{sstbl_pkg::OP_INSERT, 24'd0, 32'd0, 1, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'd0, 32'd0, 1, '{1'b1, 24'd0, 24'd0, 1'b0}},
      '{sstbl_pkg::OP_INSERT, 24'hFFFFFF, 32'hFFFFFFFF, 1, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'hFFFFFF, 32'hFFFFFFFF, 1,
        '{1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b0}},
      '{sstbl_pkg::OP_INSERT, 24'd100, 32'd1, 1, NoResult},
      '{sstbl_pkg::OP_INSERT, 24'd100, 32'd2049, 1, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'd101, 32'd0, 0, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'd100, 32'd0, 0, NoResult},
      '{sstbl_pkg::OP_INSERT, 24'hFFFFF0, 32'd40960, 1, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'hFFFFF8, 32'd0, 0, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'd50, 32'd0, 1, NoResult},
      '{sstbl_pkg::OP_NONE, 24'hFFFFFF, 32'hFFFFFFFF, 1, NoResult},
      '{sstbl_pkg::OP_INSERT, 24'd5000, 32'd2048, 1, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'd5000, 32'd0, 0, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'd5001, 32'd0, 1, NoResult},
      '{sstbl_pkg::OP_CLEAR, 24'hFFFFFF, 32'hFFFFFFFF, 1, NoResult},
      '{sstbl_pkg::OP_LOOKUP, 24'd100, 32'd0, 1, NoResult}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Wait draw for either side. Quiet stretches run with no idling at all.
   function automatic int draw_wait();
      return quiet_mode ? 0 : int'($urandom_range(0, 11));
   endfunction

   // The end sector is the start plus the whole blocks after the first byte,
   // and it saturates at the top sector.
   function automatic logic [23:0] range_end_of(logic [23:0] start, logic [31:0] size);
      logic [32:0] sum;
      sum = {9'd0, start};
      if (size != 0) sum = sum + ((size - 1) / sstbl_pkg::BlockBytes);
      return (sum > 33'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
   endfunction

   // Apply one item to the predictor's table and return its result.
   function automatic sstbl_pkg::rsp_type table_step(sstbl_pkg::req_type item);
      sstbl_pkg::rsp_type r;
      int      lo, hi, mid, pos;
      r = '0;
      case (sstbl_pkg::op_type'(item.operation))
         sstbl_pkg::OP_LOOKUP: begin
            lo = 0;
            hi = table_count - 1;
            while (lo <= hi) begin
               mid = lo + (hi - lo) / 2;
               if (table_starts[mid] <= item.sector && table_ends[mid] >= item.sector) begin
                  r.hit = 1'b1;
                  r.range_start = table_starts[mid];
                  r.range_end = table_ends[mid];
                  break;
               end
               if (table_starts[mid] > item.sector) hi = mid - 1;
               else lo = mid + 1;
            end
            if (r.hit) n_hits++;
            else n_misses++;
         end
         sstbl_pkg::OP_INSERT: begin
            if (table_count >= sstbl_pkg::MaxEntries) begin
               r.rejected = 1'b1;
               n_refused++;
            end else begin
               // The new range goes after every stored range with the same start.
               lo = 0;
               hi = table_count;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (table_starts[mid] > item.sector) hi = mid;
                  else lo = mid + 1;
               end
               pos = lo;
               for (int i = table_count; i > pos; i--) begin
                  table_starts[i] = table_starts[i - 1];
                  table_ends[i] = table_ends[i - 1];
               end
               table_starts[pos] = item.sector;
               table_ends[pos] = range_end_of(item.sector, item.byte_size);
               table_count++;
               n_inserts++;
            end
         end
         sstbl_pkg::OP_CLEAR: begin
            table_count = 0;
            n_clears++;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Present one item, hold it until it is accepted, then record the expected result.
   task automatic send_item(sstbl_pkg::req_type item, bit known, sstbl_pkg::rsp_type typed);
      int      gap;
      sstbl_pkg::rsp_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predicted = table_step(item);
      pending_results.push_back(known ? typed : predicted);
   endtask

   // Sender: directed table, then random items.
   initial begin
      sstbl_pkg::req_type item;
      int      pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      table_count = 0;
      error_count = 0;
      stimulus_done = 1'b0;
      quiet_mode = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         item = '{directed_rows[i].op, directed_rows[i].sector, directed_rows[i].size};
         send_item(item, directed_rows[i].known, directed_rows[i].result);
      end

      // Random part. Frequent clears keep the table small, so inserts stay short.
      for (int n = 0; n < NumRandom; n++) begin
         if (n % 200 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         item.byte_size = $urandom;
         if ($urandom_range(0, 2) != 0) item.byte_size = $urandom_range(0, 20000);
         if (pick < 2 || table_count > 120) begin
            item.operation = sstbl_pkg::OP_CLEAR;
            item.sector = 24'($urandom);
         end else if (pick < 4) begin
            item.operation = sstbl_pkg::OP_NONE;
            item.sector = 24'($urandom);
         end else if (pick < 45) begin
            item.operation = sstbl_pkg::OP_INSERT;
            if (table_count > 0 && $urandom_range(0, 3) == 0)
               item.sector = table_starts[$urandom_range(0, table_count - 1)];
            else if ($urandom_range(0, 7) == 0)
               item.sector = 24'($urandom);
            else
               item.sector = 24'($urandom_range(0, 4000));
         end else begin
            item.operation = sstbl_pkg::OP_LOOKUP;
            if (table_count > 0 && $urandom_range(0, 3) != 0)
               item.sector = table_starts[$urandom_range(0, table_count - 1)]
                             + 24'($urandom_range(0, 12));
            else if ($urandom_range(0, 3) == 0)
               item.sector = 24'($urandom);
            else
               item.sector = 24'($urandom_range(0, 4000));
         end
         send_item(item, 1'b0, NoResult);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Receiver: stall at random, then take one result and compare it field by field.
   initial begin
      int      hold;
      sstbl_pkg::rsp_type want;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            $display("%0t: result with no item waiting, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.range_start !== want.range_start ||
                rsp_data.range_end !== want.range_end || rsp_data.rejected !== want.rejected) begin
               $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   // End of the run: wait until every expected result has arrived, then let the
   // block settle for a short while before the verdict.
   initial begin
      wait (stimulus_done);
      wait (pending_results.size() == 0);
      repeat (100) @(posedge clock);
      $display("Covered %0d inserts (%0d refused on a full table) and %0d clears,",
               n_inserts, n_refused, n_clears);
      $display("and %0d lookups that hit and %0d that missed.", n_hits, n_misses);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a block that stops responding.
   initial begin
      #60ms;
      $display("tb: failure");
      $finish;
   end

endmodule
